### hdl/swam_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swam_pkg: shared types for the sliding window anagram matcher
// Operation codes and the per-item control flags handed from the front
// stage to the count stage.
// ---------------------------------------------------------------------------
package swam_pkg;

  localparam int CHAR_W = 8;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } op_t;

  // Decisions the front stage takes for one item
  typedef struct packed {
    logic clear;       // clear item: wipe count tables and tallies
    logic pat_add;     // pattern byte taken into the pattern table
    logic overflow;    // pattern byte dropped, pattern full
    logic txt_add;     // text byte enters the window
    logic txt_remove;  // oldest window byte leaves the window
    logic win_full;    // window holds pattern-length bytes after this item
  } ctl_t;

endpackage

### hdl/swam_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swam_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read at the address being
// written returns the old contents.
// ---------------------------------------------------------------------------
module swam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/swam_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swam_front: item decode and window bookkeeping
// Tracks pattern length, window fill, ring head and text position at the
// moment an item is accepted, keeps the window ring and presents the byte
// that leaves the window.
// ---------------------------------------------------------------------------
module swam_front #(
  parameter int MAX_PATTERN    = 64,
  parameter int ALPHABET_SIZE  = 256,
  parameter int POSITION_WIDTH = 32,
  localparam int PLW = $clog2(MAX_PATTERN + 1),
  localparam int RW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [1:0]                operation,
  input  logic [swam_pkg::CHAR_W-1:0] data_char,
  output swam_pkg::ctl_t            ctl,
  output logic [swam_pkg::CHAR_W-1:0] out_byte,
  output logic [POSITION_WIDTH-1:0] start
);
  import swam_pkg::*;

  logic [PLW-1:0]            plen_r, plen_nxt;
  logic [PLW-1:0]            fill_r, fill_nxt;
  logic [RW-1:0]             head_r, head_nxt, head_inc;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic                      started_r, started_nxt;
  logic                      ring_we;
  logic [CHAR_W-1:0]         ring_q;
  logic                      fwd_v_r, fwd_v_nxt;
  logic [CHAR_W-1:0]         fwd_d_r;
  logic                      char_ok;

  assign char_ok  = int'(data_char) < ALPHABET_SIZE;
  assign head_inc = ((PLW'(head_r) + PLW'(1)) >= plen_r) ? '0 : RW'(head_r + RW'(1));

  // Decode the item and work out the next bookkeeping state
  always_comb begin
    ctl         = '0;
    plen_nxt    = plen_r;
    fill_nxt    = fill_r;
    head_nxt    = head_r;
    pos_nxt     = pos_r;
    started_nxt = started_r;
    ring_we     = 1'b0;
    if (accept) begin
      case (op_t'(operation))
        OP_CLEAR: begin
          ctl.clear   = 1'b1;
          plen_nxt    = '0;
          fill_nxt    = '0;
          head_nxt    = '0;
          pos_nxt     = '0;
          started_nxt = 1'b0;
        end
        OP_PATTERN: begin
          if (!started_r && char_ok) begin
            if (plen_r == PLW'(MAX_PATTERN)) begin
              ctl.overflow = 1'b1;
            end else begin
              ctl.pat_add = 1'b1;
              plen_nxt    = plen_r + PLW'(1);
            end
          end
        end
        OP_TEXT: begin
          started_nxt = 1'b1;
          pos_nxt     = pos_r + POSITION_WIDTH'(1);
          if (plen_r != '0) begin
            ctl.txt_add = 1'b1;
            ring_we     = 1'b1;
            head_nxt    = head_inc;
            if (fill_r == plen_r) begin
              ctl.txt_remove = 1'b1;
            end else begin
              fill_nxt = fill_r + PLW'(1);
            end
            ctl.win_full = (fill_nxt == plen_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // First position of the window that ends at this byte
  assign start = pos_r - POSITION_WIDTH'(plen_r) + POSITION_WIDTH'(1);

  // Bypass the ring when the byte just written is the next one to leave
  assign fwd_v_nxt = ring_we && (head_r == head_nxt);
  assign out_byte  = fwd_v_r ? fwd_d_r : ring_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r    <= '0;
      fill_r    <= '0;
      head_r    <= '0;
      pos_r     <= '0;
      started_r <= 1'b0;
      fwd_v_r   <= 1'b0;
    end else begin
      plen_r    <= plen_nxt;
      fill_r    <= fill_nxt;
      head_r    <= head_nxt;
      pos_r     <= pos_nxt;
      started_r <= started_nxt;
      fwd_v_r   <= fwd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_d_r <= data_char;
  end

  // Window ring, always reading the slot at the next head
  swam_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(MAX_PATTERN)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(head_r),
    .wdata(data_char),
    .re   (1'b1),
    .raddr(head_nxt),
    .rdata(ring_q)
  );

endmodule

### hdl/swam_count.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swam_count: count tables and anagram tally
// Holds the pattern count table and the window count table (kept as an
// add tally and a remove tally so each needs one write per item), the
// distinct-value and satisfied tallies, and forms the result of one item.
// One valid bit per byte value covers all three tables: a pattern write
// zeroes both window tallies of that value, and text only writes the
// tallies of values present in the pattern.
// ---------------------------------------------------------------------------
module swam_count #(
  parameter int MAX_PATTERN    = 64,
  parameter int ALPHABET_SIZE  = 256,
  parameter int POSITION_WIDTH = 32,
  localparam int CW = $clog2(MAX_PATTERN + 1),
  localparam int AW = $clog2(ALPHABET_SIZE),
  localparam int DW = $clog2(ALPHABET_SIZE + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        fire,
  input  logic [swam_pkg::CHAR_W-1:0] data_char,
  input  logic [swam_pkg::CHAR_W-1:0] out_byte,
  input  swam_pkg::ctl_t              ctl,
  input  logic [POSITION_WIDTH-1:0]   start,
  output logic                        res_match,
  output logic [POSITION_WIDTH-1:0]   res_start,
  output logic                        res_overflow
);
  import swam_pkg::*;

  // Stage registers for the item in flight
  ctl_t                      ctl_r;
  logic [CHAR_W-1:0]         c_r, ob_r;
  logic [POSITION_WIDTH-1:0] start_r;

  // RAM read data
  logic [CW-1:0] q_pc, q_po, q_ac, q_ao, q_rc, q_ro;

  // Per-value valid bits: an invalid value reads as zero in every table
  logic [ALPHABET_SIZE-1:0] vp_r;
  logic [ALPHABET_SIZE-1:0] vp_nxt;

  // Write made at the edge the current item was loaded
  logic          lwp_v_r, lwa_v_r, lwr_v_r;
  logic [AW-1:0] lwp_a_r, lwa_a_r, lwr_a_r;
  logic [CW-1:0] lwp_d_r, lwa_d_r, lwr_d_r;

  logic [DW-1:0] sat_r, sat_nxt, sat1, sat2;
  logic [DW-1:0] dist_r, dist_nxt;

  logic [AW-1:0] c_idx, o_idx, r_wa;
  logic [CW-1:0] pc_c, pc_o, a_c, a_o, r_c, r_o;
  logic [CW-1:0] wc_o, wc_c, wc_c_new;
  logic          c_ok, o_ok, rem_ok, add_ok, same;
  logic          p_we, a_we, r_we;
  logic [CW-1:0] p_wd, a_wd, r_wd;

  assign c_idx = c_r[AW-1:0];
  assign o_idx = ob_r[AW-1:0];
  assign c_ok  = int'(c_r) < ALPHABET_SIZE;
  assign o_ok  = int'(ob_r) < ALPHABET_SIZE;

  // Current table values with the last write forwarded
  always_comb begin
    pc_c = (lwp_v_r && lwp_a_r == c_idx) ? lwp_d_r : (vp_r[c_idx] ? q_pc : '0);
    pc_o = (lwp_v_r && lwp_a_r == o_idx) ? lwp_d_r : (vp_r[o_idx] ? q_po : '0);
    a_c  = (lwa_v_r && lwa_a_r == c_idx) ? lwa_d_r : (vp_r[c_idx] ? q_ac : '0);
    a_o  = (lwa_v_r && lwa_a_r == o_idx) ? lwa_d_r : (vp_r[o_idx] ? q_ao : '0);
    r_c  = (lwr_v_r && lwr_a_r == c_idx) ? lwr_d_r : (vp_r[c_idx] ? q_rc : '0);
    r_o  = (lwr_v_r && lwr_a_r == o_idx) ? lwr_d_r : (vp_r[o_idx] ? q_ro : '0);
  end

  // Remove the leaving byte, then add the incoming byte
  always_comb begin
    same     = (c_r == ob_r);
    rem_ok   = ctl_r.txt_remove && o_ok && (pc_o != '0);
    add_ok   = ctl_r.txt_add && c_ok && (pc_c != '0);
    wc_o     = a_o - r_o;
    wc_c     = a_c - r_c - CW'(rem_ok && same);
    wc_c_new = wc_c + CW'(1);
    sat1     = sat_r - DW'(rem_ok && (wc_o == pc_o));
    sat2     = sat1 + DW'(add_ok && (wc_c_new == pc_c));
  end

  // Pattern writes also zero both window tallies of the same value
  assign p_we = fire && ctl_r.pat_add;
  assign a_we = fire && (add_ok || ctl_r.pat_add);
  assign r_we = fire && (rem_ok || ctl_r.pat_add);
  assign r_wa = ctl_r.pat_add ? c_idx : o_idx;
  assign p_wd = pc_c + CW'(1);
  assign a_wd = ctl_r.pat_add ? '0 : a_c + CW'(1);
  assign r_wd = ctl_r.pat_add ? '0 : r_o + CW'(1);

  // Tallies and valid bits
  always_comb begin
    sat_nxt  = sat_r;
    dist_nxt = dist_r;
    vp_nxt   = vp_r;
    if (fire) begin
      if (ctl_r.clear) begin
        sat_nxt  = '0;
        dist_nxt = '0;
        vp_nxt   = '0;
      end else begin
        if (ctl_r.pat_add) begin
          dist_nxt = dist_r + DW'(pc_c == '0);
        end
        if (ctl_r.txt_add) begin
          sat_nxt = sat2;
        end
        if (p_we) begin
          vp_nxt[c_idx] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r   <= '0;
      dist_r  <= '0;
      vp_r    <= '0;
      lwp_v_r <= 1'b0;
      lwa_v_r <= 1'b0;
      lwr_v_r <= 1'b0;
      ctl_r   <= '0;
    end else begin
      sat_r  <= sat_nxt;
      dist_r <= dist_nxt;
      vp_r   <= vp_nxt;
      if (accept) begin
        lwp_v_r <= p_we;
        lwa_v_r <= a_we;
        lwr_v_r <= r_we;
        ctl_r   <= ctl;
      end
    end
  end

  // Load the item and the write that races its table reads
  always_ff @(posedge clk) begin
    if (accept) begin
      c_r     <= data_char;
      ob_r    <= out_byte;
      start_r <= start;
      lwp_a_r <= c_idx;
      lwp_d_r <= p_wd;
      lwa_a_r <= c_idx;
      lwa_d_r <= a_wd;
      lwr_a_r <= r_wa;
      lwr_d_r <= r_wd;
    end
  end

  // Pattern counts, one copy per read address
  swam_ram #(.WIDTH(CW), .DEPTH(ALPHABET_SIZE)) u_pat_c (
    .clk(clk), .we(p_we), .waddr(c_idx), .wdata(p_wd),
    .re(accept), .raddr(data_char[AW-1:0]), .rdata(q_pc)
  );
  swam_ram #(.WIDTH(CW), .DEPTH(ALPHABET_SIZE)) u_pat_o (
    .clk(clk), .we(p_we), .waddr(c_idx), .wdata(p_wd),
    .re(accept), .raddr(out_byte[AW-1:0]), .rdata(q_po)
  );

  // Window add tally
  swam_ram #(.WIDTH(CW), .DEPTH(ALPHABET_SIZE)) u_add_c (
    .clk(clk), .we(a_we), .waddr(c_idx), .wdata(a_wd),
    .re(accept), .raddr(data_char[AW-1:0]), .rdata(q_ac)
  );
  swam_ram #(.WIDTH(CW), .DEPTH(ALPHABET_SIZE)) u_add_o (
    .clk(clk), .we(a_we), .waddr(c_idx), .wdata(a_wd),
    .re(accept), .raddr(out_byte[AW-1:0]), .rdata(q_ao)
  );

  // Window remove tally
  swam_ram #(.WIDTH(CW), .DEPTH(ALPHABET_SIZE)) u_rem_c (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd),
    .re(accept), .raddr(data_char[AW-1:0]), .rdata(q_rc)
  );
  swam_ram #(.WIDTH(CW), .DEPTH(ALPHABET_SIZE)) u_rem_o (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd),
    .re(accept), .raddr(out_byte[AW-1:0]), .rdata(q_ro)
  );

  // Result of the item in flight
  assign res_match    = ctl_r.win_full && (dist_r != '0) && (sat2 == dist_r);
  assign res_start    = res_match ? start_r : '0;
  assign res_overflow = ctl_r.overflow;

endmodule

### hdl/sliding_window_anagram_matcher.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_anagram_matcher: byte-stream anagram finder
// Input items carry an operation (clear, pattern byte, text byte) and a
// byte. Every item yields exactly one result item: match flag, start index
// of the matching window and a pattern-overflow flag.
// An accepted item is loaded into the count stage registers, then into the
// result register on the out_ ports. Throughput: one item per cycle while
// out_stall does not hold the flow; the count stage does both table updates
// of a text byte at once, with the write of the previous item forwarded into
// the table reads of the next. Reset (rst_n low, synchronous) empties the
// tables through per-entry valid bits, so no table sweep is needed before
// items are taken. A clear item does the same through the valid bits.
// When out_stall is high the result register holds, the count stage holds
// one more item, and in_stall rises only while both are occupied.
// ---------------------------------------------------------------------------
module sliding_window_anagram_matcher #(
  parameter int MAX_PATTERN    = 64,
  parameter int ALPHABET_SIZE  = 256,
  parameter int POSITION_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [swam_pkg::CHAR_W-1:0] in_data_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_match,
  output logic [POSITION_WIDTH-1:0]   out_start_index,
  output logic                        out_pattern_overflow
);
  import swam_pkg::*;

  ctl_t                      ctl;
  logic [CHAR_W-1:0]         out_byte;
  logic [POSITION_WIDTH-1:0] start;
  logic                      accept, fire;
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      res_match, res_overflow;
  logic [POSITION_WIDTH-1:0] res_start;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_match_r, out_overflow_r;
  logic [POSITION_WIDTH-1:0] out_start_r;

  // Handshake: advance the count stage whenever the result register frees
  assign fire         = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = s1_valid_r && !fire;
  assign accept       = in_valid && !in_stall;
  assign s1_valid_nxt = accept || (s1_valid_r && !fire);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (fire) begin
      out_match_r    <= res_match;
      out_start_r    <= res_start;
      out_overflow_r <= res_overflow;
    end
  end

  swam_front #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .operation(in_operation),
    .data_char(in_data_char),
    .ctl      (ctl),
    .out_byte (out_byte),
    .start    (start)
  );

  swam_count #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_count (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .fire        (fire),
    .data_char   (in_data_char),
    .out_byte    (out_byte),
    .ctl         (ctl),
    .start       (start),
    .res_match   (res_match),
    .res_start   (res_start),
    .res_overflow(res_overflow)
  );

  assign out_valid            = out_valid_r;
  assign out_match            = out_match_r;
  assign out_start_index      = out_start_r;
  assign out_pattern_overflow = out_overflow_r;

endmodule

### hdl/swam_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swam_checker: port-level checks for the anagram matcher
// Watches the top-level ports and is attached to every instance by bind.
// ---------------------------------------------------------------------------
module swam_checker #(
  parameter int POSITION_WIDTH = 32
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_match,
  input logic [POSITION_WIDTH-1:0] out_start_index,
  input logic                      out_pattern_overflow
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match) &&
      $stable(out_start_index) && $stable(out_pattern_overflow))
    else $error("stalled result item changed");

  // Backpressure only with a full result register that is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result path is free");

  // A match never comes from a pattern item
  a_match_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match |-> !out_pattern_overflow)
    else $error("match and overflow in one item");

  // Start index is zero unless the window matches
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_match |-> out_start_index == '0)
    else $error("start index set without a match");

endmodule

bind sliding_window_anagram_matcher swam_checker #(
  .POSITION_WIDTH(POSITION_WIDTH)
) u_swam_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_match           (out_match),
  .out_start_index     (out_start_index),
  .out_pattern_overflow(out_pattern_overflow)
);

### test/sliding_window_anagram_matcher_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_anagram_matcher_test: self-checking bench for the matcher
// Drives clear, pattern and text items with random idling on both sides.
// Each accepted item is run through an in-bench copy of the matcher, and its
// verdict is checked field by field against the next result item.
// ---------------------------------------------------------------------------
module sliding_window_anagram_matcher_test;
  import swam_pkg::*;

  localparam int          MAX_PAT    = 64;
  localparam int          ALPHA      = 256;
  localparam int          POS_W      = 32;
  localparam logic [1:0]  OP_UNKNOWN = 2'd3;
  localparam int          IDLE_PCT   = 26;
  localparam int          RANDOM_ITEMS = 1350;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
  } byte_item_t;

  typedef struct packed {
    logic             match;
    logic [POS_W-1:0] start;
    logic             overflow;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_operation = '0;
  logic [7:0] in_data_char = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_match;
  logic [POS_W-1:0] out_start_index;
  logic out_pattern_overflow;

  byte_item_t byte_items[$];
  verdict_t   window_verdicts[$];
  logic       in_fired = 1'b0;
  int         items_taken = 0;
  int         fail_count = 0;
  int         queued_count = 0;
  int         choke_left = 0;
  bit         choke_done = 1'b0;
  wire        calm = (items_taken >= 900) && (items_taken < 1150);

  // Matcher state as seen by the bench
  int unsigned      pat_count[ALPHA];
  int unsigned      win_count[ALPHA];
  int unsigned      pat_len, kinds_needed, kinds_met, fill, ring_ptr;
  logic [7:0]       ring[MAX_PAT];
  logic [POS_W-1:0] text_pos;
  bit               text_seen;

  sliding_window_anagram_matcher #(
    .MAX_PATTERN(MAX_PAT),
    .ALPHABET_SIZE(ALPHA),
    .POSITION_WIDTH(POS_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_data_char(in_data_char),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_match(out_match),
    .out_start_index(out_start_index),
    .out_pattern_overflow(out_pattern_overflow)
  );

  always #5 clk = ~clk;

  // Empty the count tables and the window
  function automatic void clear_tables();
    for (int i = 0; i < ALPHA; i++) begin
      pat_count[i] = 0;
      win_count[i] = 0;
    end
    for (int i = 0; i < MAX_PAT; i++) ring[i] = '0;
    pat_len = 0;
    kinds_needed = 0;
    kinds_met = 0;
    fill = 0;
    ring_ptr = 0;
    text_pos = '0;
    text_seen = 1'b0;
  endfunction

  // Advance the matcher by one item and return its verdict
  function automatic verdict_t anagram_step(input logic [1:0] op, input logic [7:0] ch);
    verdict_t v;
    logic [7:0] old;
    v = '0;
    case (op)
      OP_CLEAR: clear_tables();
      OP_PATTERN: begin
        if (!text_seen) begin
          if (pat_len >= MAX_PAT) begin
            v.overflow = 1'b1;
          end else begin
            if (pat_count[ch] == 0) kinds_needed++;
            pat_count[ch]++;
            pat_len++;
          end
        end
      end
      OP_TEXT: begin
        text_seen = 1'b1;
        if (pat_len > 0) begin
          // drop the oldest byte once the window is full
          if (fill >= pat_len) begin
            old = ring[ring_ptr];
            if (pat_count[old] != 0) begin
              if (win_count[old] == pat_count[old]) kinds_met--;
              if (win_count[old] > 0) win_count[old]--;
            end
          end else begin
            fill++;
          end
          ring[ring_ptr] = ch;
          ring_ptr++;
          if (ring_ptr >= pat_len) ring_ptr = 0;
          // take in the new byte
          if (pat_count[ch] != 0) begin
            win_count[ch]++;
            if (win_count[ch] == pat_count[ch]) kinds_met++;
          end
          if (fill == pat_len && kinds_needed > 0 && kinds_met == kinds_needed) begin
            v.match = 1'b1;
            v.start = text_pos - POS_W'(pat_len - 1);
          end
        end
        text_pos = text_pos + 1'b1;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic [7:0] ch);
    byte_item_t it;
    it.op = op;
    it.ch = ch;
    byte_items = {byte_items, it};
    if (op != OP_UNKNOWN) queued_count++;
  endtask

  // One clear / pattern / text session with random content
  task automatic queue_session();
    logic [7:0] letters[4];
    logic [7:0] pat[$];
    logic [7:0] tmp;
    int kind, nletters, plen, tlen, sent, r, j;
    kind = $urandom_range(99);
    // noise: any operation, any byte
    if (kind < 8) begin
      repeat ($urandom_range(5, 20)) begin
        queue_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
      return;
    end
    // mostly start clean; sometimes keep stale state so pattern bytes are ignored
    if ($urandom_range(9) != 0 || queued_count < 50) begin
      queue_item(OP_CLEAR, 8'($urandom_range(255)));
    end
    nletters = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) letters[i] = 8'($urandom_range(255));
    if (kind < 16 || queued_count < 50) plen = $urandom_range(60, 70);
    else if (kind < 20) plen = 0;
    else if (kind < 35) plen = $urandom_range(7, 20);
    else plen = $urandom_range(1, 6);
    for (int i = 0; i < plen; i++) begin
      tmp = letters[2'($urandom_range(nletters - 1))];
      if (pat.size() < MAX_PAT) pat = {pat, tmp};
      queue_item(OP_PATTERN, tmp);
    end
    tlen = (plen > 20) ? $urandom_range(plen, plen + 40) : $urandom_range(8, 40);
    sent = 0;
    while (sent < tlen) begin
      r = $urandom_range(99);
      if (r < 15 && pat.size() > 0) begin
        // shuffle the pattern and send it whole as a guaranteed anagram
        for (int i = pat.size() - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = pat[i];
          pat[i] = pat[j];
          pat[j] = tmp;
        end
        foreach (pat[i]) queue_item(OP_TEXT, pat[i]);
        sent += pat.size();
      end else begin
        if (r < 18) queue_item(OP_PATTERN, 8'($urandom_range(255)));
        else if (r < 20) queue_item(OP_UNKNOWN, 8'($urandom_range(255)));
        else if (r < 30) queue_item(OP_TEXT, 8'($urandom_range(255)));
        else queue_item(OP_TEXT, letters[2'($urandom_range(nletters - 1))]);
        sent++;
      end
    end
  endtask

  task automatic drain_results();
    while (byte_items.size() > 0 || in_valid || window_verdicts.size() > 0) @(posedge clk);
  endtask

  // Sender: offer the next item once the current one is taken
  always @(negedge clk) begin
    byte_item_t cur;
    if (rst_n && (!in_valid || in_fired)) begin
      if (byte_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        cur = byte_items.pop_front();
        in_valid <= 1'b1;
        in_operation <= cur.op;
        in_data_char <= cur.ch;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, plus one long hold-off to back up the block
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (choke_left > 0) begin
      out_stall <= 1'b1;
      choke_left--;
    end else if (!choke_done && items_taken >= 400) begin
      choke_done = 1'b1;
      choke_left = 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: predict on each accepted item, check each result item
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (window_verdicts.size() == 0) begin
          $display("%0t: unexpected result item match %0b start %0d overflow %0b",
                   $time, out_match, out_start_index, out_pattern_overflow);
          fail_count++;
        end else begin
          want = window_verdicts.pop_front();
          if (out_match !== want.match) begin
            $display("%0t: match expected %0b actual %0b", $time, want.match, out_match);
            fail_count++;
          end
          if (out_start_index !== want.start) begin
            $display("%0t: start_index expected %0d actual %0d",
                     $time, want.start, out_start_index);
            fail_count++;
          end
          if (out_pattern_overflow !== want.overflow) begin
            $display("%0t: pattern_overflow expected %0b actual %0b",
                     $time, want.overflow, out_pattern_overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        items_taken++;
        window_verdicts = {window_verdicts, anagram_step(in_operation, in_data_char)};
      end
    end
    in_fired <= rst_n && in_valid && !in_stall;
  end

  // Stimulus
  initial begin
    clear_tables();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty pattern: text never matches, position still advances
    queue_item(OP_TEXT, 8'hFF);
    queue_item(OP_TEXT, 8'h00);
    queue_item(OP_CLEAR, 8'hFF);
    // pattern with both extreme bytes
    queue_item(OP_PATTERN, 8'h00);
    queue_item(OP_PATTERN, 8'hFF);
    queue_item(OP_PATTERN, 8'h00);
    queue_item(OP_TEXT, 8'h00);
    queue_item(OP_TEXT, 8'hFF);
    queue_item(OP_TEXT, 8'h00);
    queue_item(OP_TEXT, 8'hFF);
    queue_item(OP_TEXT, 8'h00);
    // pattern after text is ignored
    queue_item(OP_PATTERN, 8'h41);
    queue_item(OP_UNKNOWN, 8'hAA);
    queue_item(OP_UNKNOWN, 8'h55);
    queue_item(OP_TEXT, 8'h55);
    queue_item(OP_TEXT, 8'hFF);
    queue_item(OP_TEXT, 8'h00);
    queue_item(OP_CLEAR, 8'h00);
    queue_item(OP_PATTERN, 8'h80);
    queue_item(OP_TEXT, 8'h80);
    queue_item(OP_TEXT, 8'h7F);
    queue_item(OP_TEXT, 8'h80);
    // pause the sender until every result is back
    drain_results();

    queued_count = 0;
    while (queued_count < RANDOM_ITEMS / 2) queue_session();
    drain_results();
    while (queued_count < RANDOM_ITEMS) queue_session();
    drain_results();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && window_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule
